>>> rtl/i2c_register_master_defines.svh
// Assertion macros used by the I2C register master top level.
`ifndef I2C_REGISTER_MASTER_DEFINES_SVH
`define I2C_REGISTER_MASTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/i2cm_pkg.sv
// Types and constants of the I2C register master.
package i2cm_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Transaction status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ACK    = 2'd1;
  localparam logic [1:0] ST_PARAM_ERR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [6:0]  DEV_ADDR_RST    = 7'd104;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd30;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

  // Bus sequencer phase codes.
  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST_A     = 5'd1;
  localparam logic [4:0] PH_ST_B     = 5'd2;
  localparam logic [4:0] PH_TX_SET   = 5'd3;
  localparam logic [4:0] PH_TX_HIGH  = 5'd4;
  localparam logic [4:0] PH_TX_LOW   = 5'd5;
  localparam logic [4:0] PH_ACK_REL  = 5'd6;
  localparam logic [4:0] PH_ACK_HIGH = 5'd7;
  localparam logic [4:0] PH_ACK_POLL = 5'd8;
  localparam logic [4:0] PH_SP_A     = 5'd9;
  localparam logic [4:0] PH_SP_B     = 5'd10;
  localparam logic [4:0] PH_SP_C     = 5'd11;
  localparam logic [4:0] PH_RX_LOW   = 5'd12;
  localparam logic [4:0] PH_RX_HIGH  = 5'd13;
  localparam logic [4:0] PH_MA_A     = 5'd14;
  localparam logic [4:0] PH_MA_B     = 5'd15;

  // Header byte steps: address+W, register, then data or address+R.
  localparam logic [1:0] STEP_ADDR = 2'd0;
  localparam logic [1:0] STEP_REG  = 2'd1;
  localparam logic [1:0] STEP_LAST = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] half_period;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_pull_low;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } res_t;

endpackage

>>> rtl/i2cm_seq.sv
// Bus sequencer of the I2C register master: state registers and one-tick update.
module i2cm_seq #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  i2cm_pkg::item_t  item_i,
  input  i2cm_pkg::cfg_t   cfg_i,
  output i2cm_pkg::res_t   res_o
);

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TMASK = '1;

  logic [4:0]             phase_q, phase_d;
  logic [3:0]             bit_q, bit_d;
  logic [7:0]             bytes_q, bytes_d;
  logic [7:0]             shift_q, shift_d;
  logic [TIMER_WIDTH-1:0] hold_q, hold_d;
  logic [TIMER_WIDTH-1:0] poll_q, poll_d;
  logic [7:0]             lreg_q, lreg_d;
  logic [7:0]             ldata_q, ldata_d;
  logic                   is_read_q, is_read_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic [1:0]             step_q, step_d;
  logic                   failed_q, failed_d;

  logic [TIMER_WIDTH-1:0] hold_inc, poll_inc;
  logic [CW-1:0]          hp_w, hp_clip, hp_eff, lim_w, ack_w, tmask_w;
  logic                   hold_hit, poll_over;
  logic [3:0]             bit_inc;
  logic [7:0]             rx_shift, bytes_dec;
  logic [7:0]             addr_w, addr_r;

  // Saturating hold and poll counters compared with the clipped limits.
  always_comb begin
    tmask_w   = CW'(TMASK);
    hp_w      = CW'(cfg_i.half_period);
    hp_clip   = (hp_w > tmask_w) ? tmask_w : hp_w;
    hp_eff    = (hp_clip == '0) ? CW'(1) : hp_clip;
    hold_inc  = (hold_q < TMASK) ? hold_q + TIMER_WIDTH'(1) : hold_q;
    hold_hit  = (CW'(hold_inc) >= hp_eff);
    ack_w     = CW'(cfg_i.ack_timeout);
    lim_w     = (ack_w >= tmask_w) ? tmask_w - CW'(1) : ack_w;
    poll_inc  = (poll_q < TMASK) ? poll_q + TIMER_WIDTH'(1) : poll_q;
    poll_over = (CW'(poll_inc) > lim_w);
    bit_inc   = bit_q + 4'd1;
    rx_shift  = (hold_q == '0) ? {shift_q[6:0], item_i.sda_in} : shift_q;
    bytes_dec = (bytes_q != 8'd0) ? bytes_q - 8'd1 : bytes_q;
    addr_w    = {cfg_i.dev_addr, 1'b0};
    addr_r    = {cfg_i.dev_addr, 1'b1};
  end

  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    bytes_d   = bytes_q;
    shift_d   = shift_q;
    hold_d    = hold_q;
    poll_d    = poll_q;
    lreg_d    = lreg_q;
    ldata_d   = ldata_q;
    is_read_d = is_read_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    step_d    = step_q;
    failed_d  = failed_q;

    res_o            = '0;
    res_o.status     = i2cm_pkg::ST_OK;

    case (phase_q)
      i2cm_pkg::PH_IDLE: begin
        if (item_i.op == i2cm_pkg::OP_WRITE || item_i.op == i2cm_pkg::OP_READ) begin
          if (item_i.op == i2cm_pkg::OP_READ && item_i.read_count == 8'd0) begin
            res_o.done_res = 1'b1;
            res_o.status   = i2cm_pkg::ST_PARAM_ERR;
          end else begin
            lreg_d    = item_i.reg_addr;
            ldata_d   = item_i.write_data;
            bytes_d   = item_i.read_count;
            is_read_d = (item_i.op == i2cm_pkg::OP_READ);
            step_d    = i2cm_pkg::STEP_ADDR;
            failed_d  = 1'b0;
            phase_d   = i2cm_pkg::PH_ST_A;
            scl_d     = 1'b1;
            sda_d     = 1'b1;
            hold_d    = '0;
          end
        end
      end
      i2cm_pkg::PH_ST_A: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_ST_B;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_ST_B: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          shift_d = (step_q == i2cm_pkg::STEP_LAST) ? addr_r : addr_w;
          bit_d   = 4'd0;
          phase_d = i2cm_pkg::PH_TX_SET;
          scl_d   = 1'b0;
          sda_d   = shift_d[7];
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_TX_SET: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_TX_HIGH;
          scl_d   = 1'b1;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_TX_HIGH: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_TX_LOW;
          scl_d   = 1'b0;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_TX_LOW: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          bit_d  = bit_inc;
          hold_d = '0;
          scl_d  = 1'b0;
          if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = i2cm_pkg::PH_TX_SET;
            sda_d   = shift_q[6];
          end else begin
            phase_d = i2cm_pkg::PH_ACK_REL;
            sda_d   = 1'b1;
          end
        end
      end
      i2cm_pkg::PH_ACK_REL: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_ACK_HIGH;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_ACK_HIGH: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_ACK_POLL;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          hold_d  = '0;
          poll_d  = '0;
        end
      end
      i2cm_pkg::PH_ACK_POLL: begin
        if (!item_i.sda_in) begin
          hold_d = '0;
          if (step_q == i2cm_pkg::STEP_ADDR || step_q == i2cm_pkg::STEP_REG) begin
            // Next header byte: register address, data for a write, or a repeated start for a read.
            step_d  = (step_q == i2cm_pkg::STEP_ADDR) ? i2cm_pkg::STEP_REG
                                                      : i2cm_pkg::STEP_LAST;
            if (step_q == i2cm_pkg::STEP_REG && is_read_q) begin
              phase_d = i2cm_pkg::PH_ST_A;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
            end else begin
              shift_d = (step_q == i2cm_pkg::STEP_ADDR) ? lreg_q : ldata_q;
              bit_d   = 4'd0;
              phase_d = i2cm_pkg::PH_TX_SET;
              scl_d   = 1'b0;
              sda_d   = shift_d[7];
            end
          end else if (is_read_q) begin
            bit_d   = 4'd0;
            shift_d = 8'd0;
            phase_d = i2cm_pkg::PH_RX_LOW;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
          end else begin
            phase_d = i2cm_pkg::PH_SP_A;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
          end
        end else begin
          poll_d = poll_inc;
          if (poll_over) begin
            failed_d = 1'b1;
            phase_d  = i2cm_pkg::PH_SP_A;
            scl_d    = 1'b0;
            sda_d    = 1'b0;
            hold_d   = '0;
          end
        end
      end
      i2cm_pkg::PH_SP_A: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_SP_B;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_SP_B: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_SP_C;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_SP_C: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d        = i2cm_pkg::PH_IDLE;
          scl_d          = 1'b1;
          sda_d          = 1'b1;
          hold_d         = '0;
          res_o.done_res = 1'b1;
          res_o.status   = failed_q ? i2cm_pkg::ST_NO_ACK : i2cm_pkg::ST_OK;
          failed_d       = 1'b0;
        end
      end
      i2cm_pkg::PH_RX_LOW: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_RX_HIGH;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_RX_HIGH: begin
        // The data bit is taken on the first tick of SCL high.
        shift_d = rx_shift;
        hold_d  = hold_inc;
        if (hold_hit) begin
          bit_d  = bit_inc;
          hold_d = '0;
          scl_d  = 1'b0;
          if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
            phase_d = i2cm_pkg::PH_RX_LOW;
            sda_d   = 1'b1;
          end else begin
            res_o.read_valid = 1'b1;
            res_o.read_data  = rx_shift;
            res_o.read_last  = (bytes_q <= 8'd1);
            phase_d          = i2cm_pkg::PH_MA_A;
            sda_d            = (bytes_q <= 8'd1);
          end
        end
      end
      i2cm_pkg::PH_MA_A: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          phase_d = i2cm_pkg::PH_MA_B;
          scl_d   = 1'b1;
          hold_d  = '0;
        end
      end
      i2cm_pkg::PH_MA_B: begin
        hold_d = hold_inc;
        if (hold_hit) begin
          bytes_d = bytes_dec;
          hold_d  = '0;
          scl_d   = 1'b0;
          if (bytes_dec != 8'd0) begin
            bit_d   = 4'd0;
            shift_d = 8'd0;
            phase_d = i2cm_pkg::PH_RX_LOW;
            sda_d   = 1'b1;
          end else begin
            phase_d = i2cm_pkg::PH_SP_A;
            sda_d   = 1'b0;
          end
        end
      end
      default: begin
        phase_d = i2cm_pkg::PH_IDLE;
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        hold_d  = '0;
      end
    endcase

    res_o.scl_out      = scl_d;
    res_o.sda_pull_low = ~sda_d;
    res_o.busy_res     = (phase_d != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2cm_pkg::PH_IDLE;
      bit_q     <= '0;
      bytes_q   <= '0;
      shift_q   <= '0;
      hold_q    <= '0;
      poll_q    <= '0;
      lreg_q    <= '0;
      ldata_q   <= '0;
      is_read_q <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      step_q    <= i2cm_pkg::STEP_ADDR;
      failed_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      bytes_q   <= bytes_d;
      shift_q   <= shift_d;
      hold_q    <= hold_d;
      poll_q    <= poll_d;
      lreg_q    <= lreg_d;
      ldata_q   <= ldata_d;
      is_read_q <= is_read_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      step_q    <= step_d;
      failed_q  <= failed_d;
    end
  end

endmodule

>>> rtl/i2c_register_master.sv
// Top level of the I2C register master: item register, configuration, result register.
//
//   Channel  Direction  Handshake                  Payload
//   in       into       in_valid_i / in_ready_o    op, reg_addr, write_data, read_count, sda_in
//   out      out of     out_valid_o / out_ready_i  scl_out .. busy_res, one result per item
//   cfg      into       cfg_we_i                   cfg_index_i, cfg_data_i
//
// Each item is one bus tick and yields one result; with out_ready_i high, one item per clock.
// An accepted item is held in the item register, stepped through the sequencer when it
// fires, and its result is then captured in the result register.
// The result register stalls on out_ready_i; the item register then holds one item more.
// Reset releases the sequencer's SCL/SDA registers and idles it; no clearing pass.
`include "i2c_register_master_defines.svh"

module i2c_register_master #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  read_count_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_pull_low_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic        read_last_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic        busy_res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  i2cm_pkg::cfg_t  cfg_q;
  i2cm_pkg::item_t item_q;
  i2cm_pkg::res_t  res_d, res_q;
  logic            in_vld_q, out_vld_q;
  logic            fire;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= i2cm_pkg::DEV_ADDR_RST;
      cfg_q.half_period <= i2cm_pkg::HALF_PERIOD_RST;
      cfg_q.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2cm_pkg::REG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_data_i[6:0];
        i2cm_pkg::REG_HALF_PERIOD: cfg_q.half_period <= cfg_data_i;
        i2cm_pkg::REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op         <= op_i;
      item_q.reg_addr   <= reg_addr_i;
      item_q.write_data <= write_data_i;
      item_q.read_count <= read_count_i;
      item_q.sda_in     <= sda_in_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  i2cm_seq #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_o    = out_vld_q;
  assign scl_out_o      = res_q.scl_out;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign read_data_o    = res_q.read_data;
  assign read_valid_o   = res_q.read_valid;
  assign read_last_o    = res_q.read_last;
  assign done_res_o     = res_q.done_res;
  assign status_o       = res_q.status;
  assign busy_res_o     = res_q.busy_res;

  // A stepped tick always leaves a result behind, and a held tick is never dropped.
  `I2CM_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, out_vld_q, "stepped tick left no result")
  `I2CM_ASSERT_NEXT(a_item_kept, clk_i, rst_ni, in_vld_q && !fire, in_vld_q, "waiting tick was lost")
  `I2CM_ASSERT_NOW(a_last_is_read, clk_i, rst_ni, out_vld_q && read_last_o, read_valid_o, "last mark without read byte")
  `I2CM_ASSERT_NOW(a_status_on_done, clk_i, rst_ni, out_vld_q && status_o != i2cm_pkg::ST_OK, done_res_o, "status without done")

endmodule
